// ===== design/hsvrgb_pkg.sv =====
// ----------------------------------------------------------------------------
// hsvrgb_pkg: shared types and constants for the HSV to RGB converter
// Field widths, fixed-point constants, hue sector codes and the per-channel
// scale factor bundle passed between the front end and the scaler.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

  // Port field widths
  localparam int HUE_W  = 15;
  localparam int Q8_W   = 10;
  localparam int CHAN_W = 8;

  // Hue in 1/16 degree: one turn and one sector
  localparam int HUE_TURN   = 5760;
  localparam int HUE_SECTOR = 960;
  localparam int HUE_OFFSET = 3 * HUE_TURN;  // lifts any 15-bit hue above zero

  // Q8 unity and the clamped width (0..256)
  localparam int Q8_ONE = 256;
  localparam int UQ_W   = 9;

  // Internal widths
  localparam int HW_W   = 16;  // hue after offset, before wrap
  localparam int H_W    = 13;  // wrapped hue 0..5759
  localparam int F_W    = 10;  // sector fraction 0..960
  localparam int V255_W = 16;  // value times 255
  localparam int K_W    = 18;  // channel factor 0..245760
  localparam int P_W    = V255_W + K_W;
  localparam int Q_W    = 12;  // product over 2^22, at most 3825

  // Channel = floor(v*255*K / (256 * 256 * 960)): the common
  // denominator is 15 * 2^22, taken as a shift and a reciprocal multiply.
  localparam int DEN_SHIFT   = 22;
  localparam int RECIP15     = 17477;  // ceil(2^18 / 15), exact for Q < 4096
  localparam int RECIP_W     = 15;
  localparam int RECIP_SHIFT = 18;

  localparam int K_MAX = Q8_ONE * HUE_SECTOR;

  // Hue sectors: which channel is max, which ramps and in what sense
  typedef enum logic [2:0] {
    SEC_R_MAX_G_UP = 3'd0,
    SEC_G_MAX_R_DN = 3'd1,
    SEC_G_MAX_B_UP = 3'd2,
    SEC_B_MAX_G_DN = 3'd3,
    SEC_B_MAX_R_UP = 3'd4,
    SEC_R_MAX_B_DN = 3'd5
  } sector_t;

  // Per-channel factors, each out of K_MAX
  typedef struct packed {
    logic [K_W-1:0] kr;
    logic [K_W-1:0] kg;
    logic [K_W-1:0] kb;
  } k_t;

endpackage

// ===== design/hsvrgb_ifs.sv =====
// ----------------------------------------------------------------------------
// hsvrgb_ifs: valid/ready channels of the HSV to RGB converter
// One interface for the HSV pixel stream and one for the RGB pixel stream.
// ----------------------------------------------------------------------------
interface hsvrgb_hsv_if;
  import hsvrgb_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [HUE_W-1:0]  hue;
  logic signed [Q8_W-1:0]   saturation;
  logic signed [Q8_W-1:0]   brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

interface hsvrgb_rgb_if;
  import hsvrgb_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;

  modport source (output valid, output red, output green, output blue,
                  input ready);
  modport sink   (input valid, input red, input green, input blue,
                  output ready);
endinterface

// ===== design/hsvrgb_front.sv =====
// ----------------------------------------------------------------------------
// hsvrgb_front: normalize, find sector, build channel factors
// Three register stages: wrap and clamp, sector and fraction, factors.
// ----------------------------------------------------------------------------
module hsvrgb_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic signed [hsvrgb_pkg::HUE_W-1:0] hue,
  input  logic signed [hsvrgb_pkg::Q8_W-1:0]  saturation,
  input  logic signed [hsvrgb_pkg::Q8_W-1:0]  brightness,
  output logic                             out_valid,
  output logic [hsvrgb_pkg::V255_W-1:0]    v255,
  output hsvrgb_pkg::k_t                   k
);
  import hsvrgb_pkg::*;

  logic vld1, vld2, vld3;

  // Stage 1: wrap hue, clamp saturation and value
  logic [HUE_W+1:0] hsum;
  logic [HW_W-1:0]  hw0, hw1, hw2, hw3;
  logic [UQ_W-1:0]  s_cl, v_cl;
  logic [H_W-1:0]   h1;
  logic [UQ_W-1:0]  s1, v1;

  always_comb begin
    hsum = {{2{hue[HUE_W-1]}}, hue} + (HUE_W+2)'(HUE_OFFSET);
    hw0  = hsum[HW_W-1:0];
    hw1  = (hw0 >= HW_W'(4 * HUE_TURN)) ? hw0 - HW_W'(4 * HUE_TURN) : hw0;
    hw2  = (hw1 >= HW_W'(2 * HUE_TURN)) ? hw1 - HW_W'(2 * HUE_TURN) : hw1;
    hw3  = (hw2 >= HW_W'(HUE_TURN))     ? hw2 - HW_W'(HUE_TURN)     : hw2;

    if (saturation[Q8_W-1]) begin
      s_cl = '0;
    end else if (saturation > Q8_W'(Q8_ONE)) begin
      s_cl = UQ_W'(Q8_ONE);
    end else begin
      s_cl = saturation[UQ_W-1:0];
    end

    if (brightness[Q8_W-1]) begin
      v_cl = '0;
    end else if (brightness > Q8_W'(Q8_ONE)) begin
      v_cl = UQ_W'(Q8_ONE);
    end else begin
      v_cl = brightness[UQ_W-1:0];
    end
  end

  // Stage 2: sector, fraction inside it, value times 255, 1 - s
  sector_t          sec_c, sec2;
  logic [H_W-1:0]   fdiff;
  logic [UQ_W+8:0]  v255_c;
  logic [F_W-1:0]   f2;
  logic [UQ_W-1:0]  s2, sd2;
  logic [V255_W-1:0] v2;

  always_comb begin
    if (h1 <= H_W'(HUE_SECTOR)) begin
      sec_c = SEC_R_MAX_G_UP;
    end else if (h1 <= H_W'(2 * HUE_SECTOR)) begin
      sec_c = SEC_G_MAX_R_DN;
    end else if (h1 <= H_W'(3 * HUE_SECTOR)) begin
      sec_c = SEC_G_MAX_B_UP;
    end else if (h1 <= H_W'(4 * HUE_SECTOR)) begin
      sec_c = SEC_B_MAX_G_DN;
    end else if (h1 <= H_W'(5 * HUE_SECTOR)) begin
      sec_c = SEC_B_MAX_R_UP;
    end else begin
      sec_c = SEC_R_MAX_B_DN;
    end

    // Rising sectors measure from the bottom edge, falling ones from the top
    case (sec_c)
      SEC_R_MAX_G_UP: fdiff = h1;
      SEC_G_MAX_R_DN: fdiff = H_W'(2 * HUE_SECTOR) - h1;
      SEC_G_MAX_B_UP: fdiff = h1 - H_W'(2 * HUE_SECTOR);
      SEC_B_MAX_G_DN: fdiff = H_W'(4 * HUE_SECTOR) - h1;
      SEC_B_MAX_R_UP: fdiff = h1 - H_W'(4 * HUE_SECTOR);
      SEC_R_MAX_B_DN: fdiff = H_W'(6 * HUE_SECTOR) - h1;
      default:        fdiff = '0;
    endcase

    v255_c = {v1, 8'd0} - {8'd0, v1};
  end

  // Stage 3: factors out of K_MAX; minimum is 960*(256-s), ramp adds f*s
  logic [F_W+UQ_W-1:0] fs;
  logic [K_W-1:0]      kmin, kmaxv;
  logic [K_W:0]        kramp_sum;
  logic [K_W-1:0]      kramp;
  k_t                  k_c;

  always_comb begin
    fs        = (F_W+UQ_W)'(f2) * (F_W+UQ_W)'(s2);
    kmin      = K_W'({sd2, 10'd0} - {4'd0, sd2, 6'd0});
    kramp_sum = {1'b0, (K_W)'(fs)} + {1'b0, kmin};
    kramp     = kramp_sum[K_W-1:0];
    kmaxv     = K_W'(K_MAX);
    case (sec2)
      SEC_R_MAX_G_UP: k_c = '{kr: kmaxv, kg: kramp, kb: kmin};
      SEC_G_MAX_R_DN: k_c = '{kr: kramp, kg: kmaxv, kb: kmin};
      SEC_G_MAX_B_UP: k_c = '{kr: kmin,  kg: kmaxv, kb: kramp};
      SEC_B_MAX_G_DN: k_c = '{kr: kmin,  kg: kramp, kb: kmaxv};
      SEC_B_MAX_R_UP: k_c = '{kr: kramp, kg: kmin,  kb: kmaxv};
      default:        k_c = '{kr: kmaxv, kg: kmin,  kb: kramp};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
    end else if (en) begin
      vld1 <= in_valid;
      vld2 <= vld1;
      vld3 <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h1   <= hw3[H_W-1:0];
      s1   <= s_cl;
      v1   <= v_cl;
      sec2 <= sec_c;
      f2   <= fdiff[F_W-1:0];
      s2   <= s1;
      sd2  <= UQ_W'(Q8_ONE) - s1;
      v2   <= v255_c[V255_W-1:0];
      k    <= k_c;
      v255 <= v2;
    end
  end

  assign out_valid = vld3;

  a_hue_wrapped: assert property (@(posedge clk) disable iff (rst)
    vld1 |-> (h1 < H_W'(HUE_TURN)))
    else $error("wrapped hue out of one turn");

  a_fraction_range: assert property (@(posedge clk) disable iff (rst)
    vld2 |-> (f2 <= F_W'(HUE_SECTOR) && sd2 <= UQ_W'(Q8_ONE)))
    else $error("sector fraction or 1-s out of range");

  a_one_channel_max: assert property (@(posedge clk) disable iff (rst)
    vld3 |-> (k.kr == K_W'(K_MAX) || k.kg == K_W'(K_MAX) || k.kb == K_W'(K_MAX)))
    else $error("no channel carries the maximum");

endmodule

// ===== design/hsvrgb_scale.sv =====
// ----------------------------------------------------------------------------
// hsvrgb_scale: turn channel factors into 8-bit channels
// Two register stages: value times factor over 2^22, then divide by 15.
// ----------------------------------------------------------------------------
module hsvrgb_scale (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [hsvrgb_pkg::V255_W-1:0] v255,
  input  hsvrgb_pkg::k_t                k,
  output logic                          out_valid,
  output logic [hsvrgb_pkg::CHAN_W-1:0] red,
  output logic [hsvrgb_pkg::CHAN_W-1:0] green,
  output logic [hsvrgb_pkg::CHAN_W-1:0] blue
);
  import hsvrgb_pkg::*;

  logic vld4, vld5;

  // Stage 4: full products, keep the bits above 2^22
  logic [P_W-1:0] pr, pg, pb;
  logic [Q_W-1:0] qr, qg, qb;

  assign pr = P_W'(v255) * P_W'(k.kr);
  assign pg = P_W'(v255) * P_W'(k.kg);
  assign pb = P_W'(v255) * P_W'(k.kb);

  // Stage 5: floor(q / 15) by reciprocal; exact over the whole q range
  logic [Q_W+RECIP_W-1:0] tr, tg, tb;

  assign tr = (Q_W+RECIP_W)'(qr) * (Q_W+RECIP_W)'(RECIP15);
  assign tg = (Q_W+RECIP_W)'(qg) * (Q_W+RECIP_W)'(RECIP15);
  assign tb = (Q_W+RECIP_W)'(qb) * (Q_W+RECIP_W)'(RECIP15);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld4 <= 1'b0;
      vld5 <= 1'b0;
    end else if (en) begin
      vld4 <= in_valid;
      vld5 <= vld4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qr    <= pr[DEN_SHIFT+Q_W-1:DEN_SHIFT];
      qg    <= pg[DEN_SHIFT+Q_W-1:DEN_SHIFT];
      qb    <= pb[DEN_SHIFT+Q_W-1:DEN_SHIFT];
      red   <= tr[RECIP_SHIFT+CHAN_W-1:RECIP_SHIFT];
      green <= tg[RECIP_SHIFT+CHAN_W-1:RECIP_SHIFT];
      blue  <= tb[RECIP_SHIFT+CHAN_W-1:RECIP_SHIFT];
    end
  end

  assign out_valid = vld5;

  a_quotient_range: assert property (@(posedge clk) disable iff (rst)
    vld4 |-> (qr <= Q_W'(15 * 255) && qg <= Q_W'(15 * 255) && qb <= Q_W'(15 * 255)))
    else $error("scaled product exceeds one full channel");

endmodule

// ===== design/hsv_to_rgb_convert_core.sv =====
// ----------------------------------------------------------------------------
// hsv_to_rgb_convert_core: HSV pixel to 8-bit RGB pixel, one per clock
// Top level: wires the front end and scaler and runs the pipeline stall.
// ----------------------------------------------------------------------------
// Usage:
//   hsv_in  (sink)   : hue in 1/16 degree (any 15-bit value, wrapped into one
//                      turn), saturation and brightness as signed Q8 clamped
//                      to 0..256. A transfer happens when valid and ready are
//                      both high at a rising edge of clk.
//   rgb_out (source) : red, green, blue, each the truncated 0..255 channel.
//                      Black comes out whenever brightness is zero or less.
// Each pixel taken on hsv_in passes through the register stages below in order to rgb_out.
// Throughput: 1 pixel per cycle while rgb_out is not stalled; five register stages
//   (wrap/clamp, sector, factors, value multiply, divide by 15) each take a new pixel every clock.
// Stall: while rgb_out holds a pixel that is not taken, every stage holds
//   and hsv_in.ready drops; nothing is lost or repeated, and a new pixel is
//   taken in the same cycle the waiting result is transferred.
// Reset: rst (synchronous, active high) clears all stage valid bits; the
//   block is empty and ready on the first cycle after reset.
// ----------------------------------------------------------------------------
module hsv_to_rgb_convert_core (
  input  logic         clk,
  input  logic         rst,
  hsvrgb_hsv_if.sink   hsv_in,
  hsvrgb_rgb_if.source rgb_out
);
  import hsvrgb_pkg::*;

  logic           en;
  logic           front_valid;
  logic [V255_W-1:0] v255;
  k_t             k;

  // Advance the whole pipe unless the output register holds an untaken pixel
  assign en           = !rgb_out.valid || rgb_out.ready;
  assign hsv_in.ready = en;

  hsvrgb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (hsv_in.valid),
    .hue        (hsv_in.hue),
    .saturation (hsv_in.saturation),
    .brightness (hsv_in.brightness),
    .out_valid  (front_valid),
    .v255       (v255),
    .k          (k)
  );

  // Last stage of the scaler doubles as the output register
  hsvrgb_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (front_valid),
    .v255      (v255),
    .k         (k),
    .out_valid (rgb_out.valid),
    .red       (rgb_out.red),
    .green     (rgb_out.green),
    .blue      (rgb_out.blue)
  );

endmodule
